// ===== design/key_prefix_triple_hash_macros.svh =====
// Assertion macros used by the key prefix hash top level.
`ifndef KEY_PREFIX_TRIPLE_HASH_MACROS_SVH
`define KEY_PREFIX_TRIPLE_HASH_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define KPTH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kpth assertion failed: same-cycle implication");

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define KPTH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kpth assertion failed: next-cycle implication");

`endif

// ===== design/kpth_pkg.sv =====
// Package: constants, types and helper functions of the key prefix hash.
`timescale 1ns / 1ps
package kpth_pkg;

    localparam logic [31:0] SEED_A  = 32'd1192827283;
    localparam logic [31:0] SEED_B  = 32'd534897851;
    localparam logic [31:0] SEED_C  = 32'd0;
    localparam logic [31:0] PRIME1  = 32'd2654435761;
    localparam logic [31:0] PRIME2  = 32'd2246822519;
    localparam logic [31:0] PRIME3  = 32'd3266489917;
    localparam logic [31:0] PRIME4  = 32'd668265263;
    localparam logic [31:0] PRIME5  = 32'd374761393;
    localparam int          ROT_AMT = 17;

    localparam logic [3:0]  LEN_MIN  = 4'd1;
    localparam logic [3:0]  LEN_MAX  = 4'd8;
    localparam logic [3:0]  LEN_WORD = 4'd4;

    // Prep stage register, then six lane stages.
    localparam int NUM_STAGES = 7;

    typedef struct packed {
        logic en;
    } t_ctl;

    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
        logic [3:0]  len;
        logic        long_key;
    } t_prep;

    function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0];
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x);
        return {x[31-ROT_AMT:0], x[31:32-ROT_AMT]};
    endfunction

endpackage

// ===== design/kpth_prep.sv =====
// Input stage: clamp the prefix length and mask the key to its prefix bytes.
`timescale 1ns / 1ps
module kpth_prep (
    input  logic           i_clk,
    input  kpth_pkg::t_ctl i_ctl,
    input  logic [63:0]    i_key,
    input  logic [3:0]     i_prefix_len,
    output kpth_pkg::t_prep o_prep
);
    import kpth_pkg::*;

    logic [3:0]  len_c;
    logic [63:0] key_m;
    t_prep       r_prep;
    t_prep       n_prep;

    always_comb begin
        if (i_prefix_len == 4'd0) begin
            len_c = LEN_MIN;
        end else if (i_prefix_len inside {[4'd9:4'd15]}) begin
            len_c = LEN_MAX;
        end else begin
            len_c = i_prefix_len;
        end
        // Keep byte b (0 is the most significant) while b is below the length.
        for (int b = 0; b < 8; b++) begin
            key_m[63-8*b -: 8] = (4'(b) < len_c) ? i_key[63-8*b -: 8] : 8'd0;
        end
        n_prep.hi       = key_m[63:32];
        n_prep.lo       = key_m[31:0];
        n_prep.len      = len_c;
        n_prep.long_key = (len_c > LEN_WORD);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;
endmodule

// ===== design/kpth_lane.sv =====
// One hash lane: two word rounds and the avalanche, at most one multiply in series per stage.
`timescale 1ns / 1ps
module kpth_lane (
    input  logic            i_clk,
    input  kpth_pkg::t_ctl  i_ctl,
    input  kpth_pkg::t_prep i_prep,
    input  logic [31:0]     i_seed,
    input  logic [31:0]     i_mult,
    output logic [31:0]     o_hash
);
    import kpth_pkg::*;

    logic [31:0] r_mhi, r_mlo, r_h0, r_h1, r_h2, r_a1, r_a2, r_out;
    logic [31:0] r_mlo2;
    logic        r_long1, r_long2;
    logic [31:0] n_h2;

    always_comb begin
        if (r_long2) begin
            n_h2 = mul_lo(rotl(r_h1 ^ r_mlo2), PRIME4);
        end else begin
            n_h2 = r_h1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            // Word products and start value.
            r_mhi   <= mul_lo(i_prep.hi, i_mult);
            r_mlo   <= mul_lo(i_prep.lo, i_mult);
            r_h0    <= PRIME5 + i_seed + {28'd0, i_prep.len};
            r_long1 <= i_prep.long_key;
            // High word round.
            r_h1    <= mul_lo(rotl(r_h0 ^ r_mhi), PRIME4);
            r_mlo2  <= r_mlo;
            r_long2 <= r_long1;
            // Low word round, only for prefixes longer than one word.
            r_h2    <= n_h2;
            // Avalanche.
            r_a1    <= mul_lo(r_h2 ^ (r_h2 >> 15), PRIME2);
            r_a2    <= mul_lo(r_a1 ^ (r_a1 >> 13), PRIME3);
            r_out   <= r_a2 ^ (r_a2 >> 16);
        end
    end

    assign o_hash = r_out;
endmodule

// ===== design/key_prefix_triple_hash.sv =====
// Top level: three-lane pipelined hash of a masked key prefix.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one key and its prefix length
//   in bytes. Length 0 is hashed as 1, lengths 9 to 15 as 8. Output channel
//   (o_valid / i_ready) carries the three hashes of that prefix: hash A with
//   seed A and PRIME1, hash B with seed B and PRIME3, hash C with seed zero
//   and PRIME3.
//   Pipeline: seven register stages, the prep register and six lane stages
//   (five multiply stages plus the output register of each lane).
//   Throughput: one transaction per cycle while the output is not stalled;
//   lanes run in parallel and no stage has more than one 32x32 multiply in series.
//   Reset: synchronous, active low; clears all valid bits and holds o_ready
//   low, so no result is presented afterwards until a new transaction enters.
//   Stall: while o_valid is high and i_ready low the whole pipeline holds,
//   o_ready drops, and nothing is lost or repeated. A bubble at the output
//   lets the pipeline advance even when i_ready is low.
`timescale 1ns / 1ps
`include "key_prefix_triple_hash_macros.svh"
module key_prefix_triple_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_key,
    input  logic [3:0]  i_prefix_len,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash_a,
    output logic [31:0] o_hash_b,
    output logic [31:0] o_hash_c
);
    import kpth_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    t_ctl                  ctl;
    t_prep                 prep;

    // Advance every stage together whenever the output slot is free or taken.
    assign ctl.en  = !r_vld[NUM_STAGES-1] || i_ready;
    // Refuse input while reset is held, since the valid bits cannot take it.
    assign o_ready = ctl.en && i_rst_n;
    assign o_valid = r_vld[NUM_STAGES-1];

    // Valid bits travel alongside the data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ctl.en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_valid};
        end
    end

    kpth_prep u_prep (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_key        (i_key),
        .i_prefix_len (i_prefix_len),
        .o_prep       (prep)
    );

    kpth_lane u_lane_a (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_prep (prep),
        .i_seed (SEED_A),
        .i_mult (PRIME1),
        .o_hash (o_hash_a)
    );

    kpth_lane u_lane_b (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_prep (prep),
        .i_seed (SEED_B),
        .i_mult (PRIME3),
        .o_hash (o_hash_b)
    );

    kpth_lane u_lane_c (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_prep (prep),
        .i_seed (SEED_C),
        .i_mult (PRIME3),
        .o_hash (o_hash_c)
    );

    // An accepted transaction lands in the prep stage.
    `KPTH_ASSERT_NXT(a_accept_enters, i_valid && o_ready, r_vld[0])
    // A stall freezes every valid bit.
    `KPTH_ASSERT_NXT(a_stall_holds, !ctl.en, $stable(r_vld))
    // Clamped length stays within one to eight bytes.
    `KPTH_ASSERT_IMP(a_len_clamped, r_vld[0], (prep.len >= LEN_MIN) && (prep.len <= LEN_MAX))
    // A prefix of one word or less leaves the low word zero.
    `KPTH_ASSERT_IMP(a_short_lo_zero, r_vld[0] && !prep.long_key, prep.lo == 32'd0)
endmodule
